// ===== sv/clbs_pkg.sv =====
// shared types and constants of the lcd bus sequencer
package clbs_pkg;

    // input kind codes
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;

    // highest cursor position taken
    localparam logic [7:0] POS_MAX = 8'd63;

    // configuration register indexes
    localparam logic REG_BUS_4BIT     = 1'b0;
    localparam logic REG_SETUP_TICKS  = 1'b1;

    // configuration reset values
    localparam logic       BUS_4BIT_RESET    = 1'b0;
    localparam logic [7:0] SETUP_TICKS_RESET = 8'd10;

    // nibble shift for the second strobe in 4-bit mode
    localparam int NIBBLE_SHIFT = 4;

    // ddram base address of each display row
    localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

    // classified operation passed from front to back
    typedef enum logic {
        OP_TICK,
        OP_REQ
    } clbs_op_t;

    // one queued word
    typedef struct packed {
        clbs_op_t   op;
        logic [7:0] data;
        logic       sel;
        logic       busy;
    } clbs_entry_t;

endpackage

// ===== sv/clbs_front.sv =====
// input front end: classifies incoming words and queues them for the sequencer
module clbs_front
    import clbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  value,
    input  logic        is_data,
    input  logic [7:0]  position,
    input  logic        busy_pin,
    output logic        q_valid,
    output clbs_entry_t q_entry,
    input  logic        q_pop
);

    clbs_entry_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    clbs_entry_t cls;
    logic        push;

    // classify the incoming word
    always_comb
    begin
        cls.op   = OP_TICK;
        cls.data = 8'd0;
        cls.sel  = 1'b0;
        cls.busy = busy_pin;
        unique case (kind)
            KIND_WRITE:
            begin
                cls.op   = OP_REQ;
                cls.data = value;
                cls.sel  = is_data;
            end
            KIND_CURSOR:
            begin
                if (position <= POS_MAX)
                begin
                    cls.op   = OP_REQ;
                    cls.data = ROW_BASE[position[5:4]] + {4'd0, position[3:0]};
                end
            end
            default:
            begin
                cls.op = OP_TICK;
            end
        endcase
    end

    // two-entry queue control
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid & in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== sv/clbs_back.sv =====
// bus sequencer back end: pin phase machine and result register
module clbs_back
    import clbs_pkg::*;
#(
    parameter int WAIT_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_4bit,
    input  logic [7:0]  cfg_setup,
    input  logic        q_valid,
    input  clbs_entry_t q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        enable_pin,
    output logic        select_pin,
    output logic        read_pin,
    output logic [7:0]  bus_out,
    output logic        bus_is_input,
    output logic        ready_res,
    output logic        accepted
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_POLL_DIR,
        PH_POLL_RW,
        PH_POLL_EH,
        PH_POLL_EL_BUSY,
        PH_POLL_EL_FREE,
        PH_SEL,
        PH_WR_LOW,
        PH_DRIVE,
        PH_STB_HI,
        PH_STB_LO
    } phase_t;

    typedef struct packed {
        logic       e;
        logic       rw;
        logic       rs;
        logic       inp;
        logic [7:0] bus;
    } pins_t;

    localparam int CW = (WAIT_BITS > 8) ? WAIT_BITS : 8;
    localparam logic [CW-1:0] LIMIT = CW'((1 << WAIT_BITS) - 1);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [WAIT_BITS-1:0] wait_reg;
    logic [WAIT_BITS-1:0] wait_next;
    logic [7:0]           byte_reg;
    logic [7:0]           byte_next;
    logic                 sel_reg;
    logic                 sel_next;
    logic                 second_reg;
    logic                 second_next;
    pins_t                pins_reg;
    pins_t                pins_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    pins_t                out_pins_reg;
    logic                 ready_res_reg;
    logic                 accepted_reg;

    logic [CW-1:0]        setup_ext;
    logic [CW-1:0]        hold_ext;
    logic [WAIT_BITS-1:0] hold;
    logic                 acc;
    logic                 do_enter;
    phase_t               tgt;

    // hold length per pin step, at least one tick, saturating at the counter
    always_comb
    begin
        setup_ext = CW'(cfg_setup);
        hold_ext  = setup_ext;
        if (setup_ext == '0)
        begin
            hold_ext = CW'(1);
        end
        if (hold_ext > LIMIT)
        begin
            hold_ext = LIMIT;
        end
        hold = hold_ext[WAIT_BITS-1:0];
    end

    // take the next word whenever the result register is free
    assign q_pop          = q_valid & (~out_valid_reg | out_ready);
    assign out_valid_next = q_pop | (out_valid_reg & ~out_ready);

    // one sequencer step per word
    always_comb
    begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        byte_next   = byte_reg;
        sel_next    = sel_reg;
        second_next = second_reg;
        pins_next   = pins_reg;
        do_enter    = 1'b0;
        tgt         = PH_IDLE;
        acc         = (phase_reg == PH_IDLE) && (q_entry.op == OP_REQ);

        if (acc)
        begin
            byte_next   = q_entry.data;
            sel_next    = q_entry.sel;
            second_next = 1'b0;
            do_enter    = 1'b1;
            tgt         = PH_POLL_DIR;
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (wait_reg > WAIT_BITS'(1))
            begin
                wait_next = wait_reg - WAIT_BITS'(1);
            end
            else
            begin
                do_enter = 1'b1;
                unique case (phase_reg)
                    PH_POLL_DIR:     tgt = PH_POLL_RW;
                    PH_POLL_RW:      tgt = PH_POLL_EH;
                    PH_POLL_EH:      tgt = q_entry.busy ? PH_POLL_EL_BUSY : PH_POLL_EL_FREE;
                    PH_POLL_EL_BUSY: tgt = PH_POLL_DIR;
                    PH_POLL_EL_FREE: tgt = PH_SEL;
                    PH_SEL:          tgt = PH_WR_LOW;
                    PH_WR_LOW:       tgt = PH_DRIVE;
                    PH_DRIVE:        tgt = PH_STB_HI;
                    PH_STB_HI:       tgt = PH_STB_LO;
                    PH_STB_LO:
                    begin
                        if (cfg_4bit && !second_reg)
                        begin
                            second_next = 1'b1;
                            byte_next   = byte_reg << NIBBLE_SHIFT;
                            tgt         = PH_DRIVE;
                        end
                        else
                        begin
                            second_next = 1'b0;
                            tgt         = PH_IDLE;
                        end
                    end
                    default:         tgt = PH_IDLE;
                endcase
            end
        end

        // pin change on entry to a phase
        if (do_enter)
        begin
            phase_next = tgt;
            wait_next  = (tgt == PH_IDLE) ? '0 : hold;
            unique case (tgt)
                PH_POLL_DIR:
                begin
                    pins_next.inp = 1'b1;
                    pins_next.rs  = 1'b0;
                end
                PH_POLL_RW:      pins_next.rw = 1'b1;
                PH_POLL_EH:      pins_next.e  = 1'b1;
                PH_POLL_EL_BUSY: pins_next.e  = 1'b0;
                PH_POLL_EL_FREE: pins_next.e  = 1'b0;
                PH_SEL:
                begin
                    pins_next.inp = 1'b0;
                    pins_next.rs  = sel_reg;
                end
                PH_WR_LOW:
                begin
                    pins_next.rw = 1'b0;
                    pins_next.e  = 1'b0;
                end
                PH_DRIVE:        pins_next.bus = byte_next;
                PH_STB_HI:       pins_next.e   = 1'b1;
                PH_STB_LO:       pins_next.e   = 1'b0;
                default:         pins_next     = pins_reg;
            endcase
        end
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= '0;
            byte_reg      <= 8'd0;
            sel_reg       <= 1'b0;
            second_reg    <= 1'b0;
            pins_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg  <= phase_next;
                wait_reg   <= wait_next;
                byte_reg   <= byte_next;
                sel_reg    <= sel_next;
                second_reg <= second_next;
                pins_reg   <= pins_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_pins_reg  <= pins_next;
            ready_res_reg <= (phase_next == PH_IDLE);
            accepted_reg  <= acc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign enable_pin   = out_pins_reg.e;
    assign select_pin   = out_pins_reg.rs;
    assign read_pin     = out_pins_reg.rw;
    assign bus_out      = out_pins_reg.bus;
    assign bus_is_input = out_pins_reg.inp;
    assign ready_res    = ready_res_reg;
    assign accepted     = accepted_reg;

endmodule

// ===== sv/char_lcd_bus_sequencer_unit.sv =====
// top level of the lcd bus sequencer: config registers, front end and sequencer
//
//  channel   signals                                  direction
//  -------   --------------------------------------   ---------
//  input     in_valid/in_ready + kind..busy_pin       into block
//  result    out_valid/out_ready + enable_pin..acc    out of block
//  config    psel/penable/pwrite/paddr/pwdata/prdata   apb slave
//
//  one word per clock sustained while out_ready stays high; each word is one step
//  of the pin sequencer in the back end, and a word's result is registered at the
//  edge it leaves the queue.
//  reset: sequencer idle, pin state low (result register not reset), bus_4bit 0, setup_ticks 10.
//  out_ready low holds the result; the two-entry queue then fills and in_ready
//  drops, and the front keeps taking words while the queue has room.
module char_lcd_bus_sequencer_unit
    import clbs_pkg::*;
#(
    parameter int WAIT_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  value,
    input  logic        is_data,
    input  logic [7:0]  position,
    input  logic        busy_pin,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        enable_pin,
    output logic        select_pin,
    output logic        read_pin,
    output logic [7:0]  bus_out,
    output logic        bus_is_input,
    output logic        ready_res,
    output logic        accepted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        bus_4bit_reg;
    logic [7:0]  setup_ticks_reg;
    logic        cfg_write;
    logic        q_valid;
    logic        q_pop;
    clbs_entry_t q_entry;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_4bit_reg    <= BUS_4BIT_RESET;
            setup_ticks_reg <= SETUP_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_BUS_4BIT:    bus_4bit_reg    <= pwdata[0];
                REG_SETUP_TICKS: setup_ticks_reg <= pwdata[7:0];
                default:         bus_4bit_reg    <= bus_4bit_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            REG_BUS_4BIT:    prdata = {31'd0, bus_4bit_reg};
            REG_SETUP_TICKS: prdata = {24'd0, setup_ticks_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // word classification and queue
    clbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .value    (value),
        .is_data  (is_data),
        .position (position),
        .busy_pin (busy_pin),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // pin sequencer
    clbs_back #(
        .WAIT_BITS (WAIT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_4bit     (bus_4bit_reg),
        .cfg_setup    (setup_ticks_reg),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .enable_pin   (enable_pin),
        .select_pin   (select_pin),
        .read_pin     (read_pin),
        .bus_out      (bus_out),
        .bus_is_input (bus_is_input),
        .ready_res    (ready_res),
        .accepted     (accepted)
    );

endmodule

// ===== bench/char_lcd_bus_sequencer_unit_test.sv =====
// self-checking testbench for the lcd bus sequencer: predicted pin levels per word
module char_lcd_bus_sequencer_unit_test;
    import clbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAIT_BITS = 8;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 140;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // pin sequencer steps as seen from the bus
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RELEASE,
        ST_READ_MODE,
        ST_POLL_HIGH,
        ST_POLL_LOW_BUSY,
        ST_POLL_LOW_FREE,
        ST_SELECT,
        ST_WRITE_MODE,
        ST_DRIVE,
        ST_STROBE_HIGH,
        ST_STROBE_LOW
    } seq_state_t;

    // pin levels and flags carried by one result word
    typedef struct packed {
        logic       pin_e;
        logic       pin_rs;
        logic       pin_rw;
        logic [7:0] pin_bus;
        logic       pin_in;
        logic       idle;
        logic       taken;
    } lcd_pins_t;

    // pin sequencer predictor and queue of expected pin words
    class lcd_pin_scoreboard;
        bit             mode_4bit;
        bit [7:0]       hold_cfg;
        seq_state_t     state;
        int             hold_left;
        bit [7:0]       byte_q;
        bit             byte_rs;
        bit             nibble_two;
        lcd_pins_t      pins;
        lcd_pins_t      expected_q[$];
        int             errors;
        int             checked;
        int             taken;
        int             refused;
        int             busy_polls;

        function new();
            mode_4bit = BUS_4BIT_RESET;
            hold_cfg = SETUP_TICKS_RESET;
            state = ST_IDLE;
            hold_left = 0;
            byte_q = '0;
            byte_rs = 1'b0;
            nibble_two = 1'b0;
            pins = '0;
        endfunction

        function int hold_len();
            int t;
            t = int'(hold_cfg);
            if (t == 0)
                t = 1;
            if (t > (1 << WAIT_BITS) - 1)
                t = (1 << WAIT_BITS) - 1;
            return t;
        endfunction

        // enter a step and apply its pin change
        function void go(seq_state_t s);
            state = s;
            case (s)
                ST_RELEASE:
                begin
                    pins.pin_in = 1'b1;
                    pins.pin_rs = 1'b0;
                end
                ST_READ_MODE:     pins.pin_rw = 1'b1;
                ST_POLL_HIGH:     pins.pin_e = 1'b1;
                ST_POLL_LOW_BUSY,
                ST_POLL_LOW_FREE: pins.pin_e = 1'b0;
                ST_SELECT:
                begin
                    pins.pin_in = 1'b0;
                    pins.pin_rs = byte_rs;
                end
                ST_WRITE_MODE:
                begin
                    pins.pin_rw = 1'b0;
                    pins.pin_e = 1'b0;
                end
                ST_DRIVE:         pins.pin_bus = byte_q;
                ST_STROBE_HIGH:   pins.pin_e = 1'b1;
                ST_STROBE_LOW:    pins.pin_e = 1'b0;
                default:          state = ST_IDLE;
            endcase
            hold_left = (state == ST_IDLE) ? 0 : hold_len();
        endfunction

        // one tick of the sequencer
        function void advance(bit busy);
            if (state == ST_IDLE)
                return;
            if (hold_left > 1)
            begin
                hold_left--;
                return;
            end
            case (state)
                ST_POLL_HIGH:
                begin
                    if (busy)
                        busy_polls++;
                    go(busy ? ST_POLL_LOW_BUSY : ST_POLL_LOW_FREE);
                end
                ST_POLL_LOW_BUSY: go(ST_RELEASE);
                ST_POLL_LOW_FREE: go(ST_SELECT);
                ST_STROBE_LOW:
                begin
                    // 4-bit mode sends the low nibble in a second strobe
                    if (mode_4bit && !nibble_two)
                    begin
                        nibble_two = 1'b1;
                        byte_q = byte_q << NIBBLE_SHIFT;
                        go(ST_DRIVE);
                    end
                    else
                    begin
                        nibble_two = 1'b0;
                        go(ST_IDLE);
                    end
                end
                default: go(seq_state_t'(state + 1));
            endcase
        endfunction

        function void note_input(logic [1:0] k, logic [7:0] v, logic d, logic [7:0] p, logic b);
            bit acc;
            lcd_pins_t exp_w;
            acc = 1'b0;
            if (state == ST_IDLE && k == KIND_WRITE)
            begin
                byte_q = v;
                byte_rs = d;
                acc = 1'b1;
            end
            else if (state == ST_IDLE && k == KIND_CURSOR && p <= POS_MAX)
            begin
                // row base plus column within the row
                byte_q = ROW_BASE[p[5:4]] + {4'd0, p[3:0]};
                byte_rs = 1'b0;
                acc = 1'b1;
            end
            if (acc)
            begin
                taken++;
                nibble_two = 1'b0;
                go(ST_RELEASE);
            end
            else
            begin
                if (k == KIND_WRITE || k == KIND_CURSOR)
                    refused++;
                advance(b);
            end
            exp_w = pins;
            exp_w.idle = (state == ST_IDLE);
            exp_w.taken = acc;
            expected_q.push_back(exp_w);
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("mismatch at result %0d: %s", checked, msg);
            errors++;
        endtask

        task cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v)
                report($sformatf("%s expected %0h got %0h", name, exp_v, got_v));
        endtask

        task check_result(lcd_pins_t got);
            lcd_pins_t exp_w;
            if (expected_q.size() == 0)
            begin
                report("result word with no input word pending");
                return;
            end
            exp_w = expected_q.pop_front();
            cmp_field("enable_pin", 8'(exp_w.pin_e), 8'(got.pin_e));
            cmp_field("select_pin", 8'(exp_w.pin_rs), 8'(got.pin_rs));
            cmp_field("read_pin", 8'(exp_w.pin_rw), 8'(got.pin_rw));
            cmp_field("bus_out", exp_w.pin_bus, got.pin_bus);
            cmp_field("bus_is_input", 8'(exp_w.pin_in), 8'(got.pin_in));
            cmp_field("ready_res", 8'(exp_w.idle), 8'(got.idle));
            cmp_field("accepted", 8'(exp_w.taken), 8'(got.taken));
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        is_data;
    logic [7:0]  position;
    logic        busy_pin;
    logic        out_valid;
    logic        out_ready;
    logic        enable_pin;
    logic        select_pin;
    logic        read_pin;
    logic [7:0]  bus_out;
    logic        bus_is_input;
    logic        ready_res;
    logic        accepted;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcd_pin_scoreboard sb = new();
    int words_in;
    int burst_left;
    int settings_run;
    int stuck_cycles;
    int rx_mode;
    bit hold_req;

    char_lcd_bus_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .is_data      (is_data),
        .position     (position),
        .busy_pin     (busy_pin),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .enable_pin   (enable_pin),
        .select_pin   (select_pin),
        .read_pin     (read_pin),
        .bus_out      (bus_out),
        .bus_is_input (bus_is_input),
        .ready_res    (ready_res),
        .accepted     (accepted),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls: a long hold on request, else the current pattern
    initial
    begin
        int pat_cnt;
        pat_cnt = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: out_ready = 1'b1;
                    1: out_ready = ($urandom_range(0, 3) != 0);
                    2: out_ready = ((pat_cnt % 5) < 3);
                    default: out_ready = ($urandom_range(0, 2) == 0);
                endcase
                pat_cnt++;
            end
        end
    end

    // sample both channels, check results, watch for a hang
    always @(posedge clk)
    begin
        lcd_pins_t got;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && in_ready)
            begin
                sb.note_input(kind, value, is_data, position, busy_pin);
                words_in++;
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                got.pin_e = enable_pin;
                got.pin_rs = select_pin;
                got.pin_rw = read_pin;
                got.pin_bus = bus_out;
                got.pin_in = bus_is_input;
                got.idle = ready_res;
                got.taken = accepted;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (moved)
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // move to the next input slot, inserting a random gap between bursts
    task to_next_slot();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        @(negedge clk);
    endtask

    // present one word and wait for it to be taken
    task offer(logic [1:0] k, logic [7:0] v, logic d, logic [7:0] p, logic b);
        kind = k;
        value = v;
        is_data = d;
        position = p;
        busy_pin = b;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task send_item(logic [1:0] k, logic [7:0] v, logic d, logic [7:0] p, logic b);
        to_next_slot();
        offer(k, v, d, p, b);
    endtask

    // ticks until the sequencer is back to idle; the second word is a refused write
    task tick_until_idle(int busy_ticks);
        int n;
        n = 0;
        forever
        begin
            to_next_slot();
            if (sb.state == ST_IDLE)
            begin
                in_valid = 1'b0;
                break;
            end
            n++;
            offer((n == 2) ? KIND_WRITE : KIND_TICK, 8'($urandom),
                  1'($urandom_range(0, 1)), 8'($urandom), (n <= busy_ticks));
        end
    endtask

    task run_request(logic [1:0] k, logic [7:0] v, logic d, logic [7:0] p, int busy_ticks);
        send_item(k, v, d, p, 1'b0);
        tick_until_idle(busy_ticks);
    endtask

    // one random word, mostly well-formed requests while idle and ticks while busy
    task send_random();
        int r;
        logic [1:0] k;
        logic [7:0] v;
        logic       d;
        logic [7:0] p;
        logic       b;
        to_next_slot();
        r = $urandom_range(0, 99);
        v = 8'($urandom);
        d = 1'($urandom_range(0, 1));
        p = 8'($urandom);
        b = ($urandom_range(0, 3) == 0);
        if (sb.state == ST_IDLE)
        begin
            if (r < 45)
                k = KIND_WRITE;
            else if (r < 85)
            begin
                k = KIND_CURSOR;
                if (r < 78)
                    p = 8'($urandom_range(0, POS_MAX));
            end
            else
                k = (r < 95) ? KIND_TICK : KIND_SPARE;
        end
        else
        begin
            if (r < 86)
                k = KIND_TICK;
            else if (r < 92)
                k = KIND_WRITE;
            else if (r < 96)
                k = KIND_CURSOR;
            else
                k = KIND_SPARE;
        end
        offer(k, v, d, p, b);
    endtask

    // stop sending and wait for every expected word
    task drain();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write followed by a read back of the same register
    task cfg_write(logic idx, logic [31:0] data, logic [31:0] mask);
        logic [31:0] rd;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if ((rd & mask) !== (data & mask))
            sb.report($sformatf("register at %0h reads %0h after writing %0h",
                                {idx, 2'b00}, rd, data));
    endtask

    task set_config(bit mode, bit [7:0] ticks);
        drain();
        cfg_write(REG_BUS_4BIT, {31'd0, mode}, 32'h1);
        cfg_write(REG_SETUP_TICKS, {24'd0, ticks}, 32'hFF);
        sb.mode_4bit = mode;
        sb.hold_cfg = ticks;
        settings_run++;
    endtask

    // stimulus
    initial
    begin
        bit       ph_mode [8];
        bit [7:0] ph_ticks [8];
        ph_mode = '{0, 1, 1, 0, 1, 0, 1, 0};
        ph_ticks = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd1, 8'd10, 8'd4, 8'd1};
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_TICK;
        value = '0;
        is_data = 1'b0;
        position = '0;
        busy_pin = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        rx_mode = 0;
        burst_left = 0;
        settings_run = 1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: idle pins, unused kind, cursor out of range, full write
        send_item(KIND_TICK, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(KIND_SPARE, 8'hFF, 1'b1, 8'hFF, 1'b1);
        send_item(KIND_CURSOR, 8'h00, 1'b0, POS_MAX + 8'd1, 1'b0);
        send_item(KIND_CURSOR, 8'h00, 1'b0, 8'hFF, 1'b0);
        run_request(KIND_WRITE, 8'hA5, 1'b1, 8'h00, 0);

        // zero hold: busy on the first poll, byte extremes, cursor corners
        set_config(1'b0, 8'd0);
        run_request(KIND_WRITE, 8'hFF, 1'b1, 8'h00, 3);
        run_request(KIND_WRITE, 8'h00, 1'b0, 8'hFF, 0);
        run_request(KIND_CURSOR, 8'hFF, 1'b1, 8'd0, 0);
        run_request(KIND_CURSOR, 8'h00, 1'b0, POS_MAX, 0);

        // 4-bit mode, then a mode change while a write is under way
        set_config(1'b1, 8'd1);
        run_request(KIND_CURSOR, 8'hFF, 1'b1, 8'd47, 3);
        run_request(KIND_WRITE, 8'h3C, 1'b1, 8'd200, 0);
        send_item(KIND_WRITE, 8'h96, 1'b1, 8'h00, 1'b0);
        repeat (4) send_item(KIND_TICK, 8'($urandom), 1'b0, 8'($urandom), 1'b0);
        set_config(1'b0, 8'd1);
        tick_until_idle(0);

        // random phases over several settings and stall patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(ph_mode[ph], ph_ticks[ph]);
            rx_mode = ph % 4;
            if (ph == 2)
                hold_req = 1'b1;
            repeat (PHASE_WORDS) send_random();
        end

        // long hold in 4-bit mode
        set_config(1'b1, 8'd60);
        rx_mode = 1;
        run_request(KIND_WRITE, 8'h5A, 1'b1, 8'h00, 0);

        drain();
        repeat (8) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d expected words never came", sb.expected_q.size()));
        $display("covered %0d words: %0d requests taken, %0d refused, %0d results checked",
                 words_in, sb.taken, sb.refused, sb.checked);
        $display("over %0d register settings in both bus modes, holds 0 to 60, %0d busy polls",
                 settings_run, sb.busy_polls);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
